[rtl/core/pmi_pkg.sv]
// Shared constants and saturation helpers for the peak mean interval block.
`default_nettype none

package pmi_pkg;

  localparam int AMP_W           = 24;
  localparam int MEAN_W          = 24;
  localparam int PCNT_W          = 17;
  localparam int FLAG_W          = 2;
  localparam int OUT_DATA_W      = ((MEAN_W + PCNT_W + 7) / 8) * 8;
  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QDEPTH_DEF      = 2;

  localparam logic [63:0] MEAN_MAX = 64'h0000_0000_00FF_FFFF;
  localparam logic [63:0] PCNT_MAX = 64'h0000_0000_0001_FFFF;

  function automatic logic [MEAN_W-1:0] sat_mean(input logic [63:0] v);
    logic [MEAN_W-1:0] r;
    if (v > MEAN_MAX) begin
      r = '1;
    end else begin
      r = v[MEAN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [PCNT_W-1:0] sat_pcnt(input logic [63:0] v);
    logic [PCNT_W-1:0] r;
    if (v > PCNT_MAX) begin
      r = '1;
    end else begin
      r = v[PCNT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/pmi_front.sv]
// Sample window, peak tests and per-stream counters; emits one job per stream.
`default_nettype none

module pmi_front import pmi_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int IDX_W = $clog2(MAX_SAMPLES),
  localparam int JOB_W = CNT_W + IDX_W + CNT_W + 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [AMP_W-1:0] in_amplitude,
  input  wire logic             in_last,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output logic [JOB_W-1:0]      job_data
);

  localparam int SW = SAMPLE_BITS;

  logic [SW-1:0]    w_r [4];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] peaks_r;
  logic [IDX_W-1:0] first_r;
  logic [IDX_W-1:0] last_r;
  logic             ovf_r;

  logic             accept;
  logic             push_en;
  logic [31:0]      amp_ext;
  logic [SW-1:0]    x;
  logic [SW-1:0]    wn [4];
  logic [CNT_W-1:0] n;
  logic             p0;
  logic             pa;
  logic             pb;
  logic [CNT_W-1:0] pk_nxt;
  logic [IDX_W-1:0] first_nxt;
  logic [IDX_W-1:0] last_nxt;
  logic [IDX_W-1:0] idx0;
  logic [IDX_W-1:0] idxa;
  logic [IDX_W-1:0] idxb;
  logic             ovf_nxt;
  logic [IDX_W-1:0] diff;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign push_en  = cnt_r < CNT_W'(MAX_SAMPLES);
  assign amp_ext  = 32'(in_amplitude);
  assign x        = amp_ext[SW-1:0];
  assign ovf_nxt  = ovf_r || !push_en;

  always_comb begin
    if (push_en) begin
      wn[0] = x;
      wn[1] = w_r[0];
      wn[2] = w_r[1];
      wn[3] = w_r[2];
      n     = cnt_r + CNT_W'(1);
    end else begin
      wn[0] = w_r[0];
      wn[1] = w_r[1];
      wn[2] = w_r[2];
      wn[3] = w_r[3];
      n     = cnt_r;
    end

    p0 = push_en && (cnt_r >= CNT_W'(2)) && (w_r[1] >= w_r[0]) && (w_r[1] >= x)
         && ((cnt_r < CNT_W'(3)) || (w_r[1] >= w_r[2]))
         && ((cnt_r < CNT_W'(4)) || (w_r[1] >= w_r[3]));
    pa = in_last && (n >= CNT_W'(2)) && (wn[1] >= wn[0])
         && ((n < CNT_W'(3)) || (wn[1] >= wn[2]))
         && ((n < CNT_W'(4)) || (wn[1] >= wn[3]));
    pb = in_last && (n >= CNT_W'(1))
         && ((n < CNT_W'(2)) || (wn[0] >= wn[1]))
         && ((n < CNT_W'(3)) || (wn[0] >= wn[2]));

    idx0 = IDX_W'(cnt_r - CNT_W'(2));
    idxa = IDX_W'(n - CNT_W'(2));
    idxb = IDX_W'(n - CNT_W'(1));

    pk_nxt    = peaks_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    if (p0) begin
      if (pk_nxt == '0) begin
        first_nxt = idx0;
      end
      last_nxt = idx0;
      pk_nxt   = pk_nxt + CNT_W'(1);
    end
    if (pa) begin
      if (pk_nxt == '0) begin
        first_nxt = idxa;
      end
      last_nxt = idxa;
      pk_nxt   = pk_nxt + CNT_W'(1);
    end
    if (pb) begin
      if (pk_nxt == '0) begin
        first_nxt = idxb;
      end
      last_nxt = idxb;
      pk_nxt   = pk_nxt + CNT_W'(1);
    end
    diff = last_nxt - first_nxt;
  end

  assign job_valid = in_valid && in_last;
  assign job_data  = {ovf_nxt, pk_nxt, diff, n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      peaks_r <= '0;
      first_r <= '0;
      last_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        cnt_r   <= '0;
        peaks_r <= '0;
        first_r <= '0;
        last_r  <= '0;
        ovf_r   <= 1'b0;
      end else begin
        cnt_r   <= n;
        peaks_r <= pk_nxt;
        first_r <= first_nxt;
        last_r  <= last_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_en) begin
      w_r[0] <= wn[0];
      w_r[1] <= wn[1];
      w_r[2] <= wn[2];
      w_r[3] <= wn[3];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond limit");
  a_peaks_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    peaks_r <= cnt_r)
    else $error("more peaks than samples");
`endif

endmodule

`default_nettype wire

[rtl/core/pmi_queue.sv]
// Small register queue that decouples the sample front from the divider back.
`default_nettype none

module pmi_queue import pmi_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QDEPTH_DEF,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = cnt_r < CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill beyond depth");
`endif

endmodule

`default_nettype wire

[rtl/core/pmi_back.sv]
// Per-stream result: bit-serial peak span/gaps or sample count, then output register.
`default_nettype none

module pmi_back import pmi_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int IDX_W = $clog2(MAX_SAMPLES),
  localparam int JOB_W = CNT_W + IDX_W + CNT_W + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  job_valid,
  output logic                       job_ready,
  input  wire logic [JOB_W-1:0]      job_data,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [FLAG_W-1:0]          out_tuser
);

  localparam int NUM_W  = IDX_W + FRAC_BITS;
  localparam int ITER_W = $clog2(NUM_W + 1);
  localparam int PAD_W  = OUT_DATA_W - MEAN_W - PCNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r;
  logic [NUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [ITER_W-1:0] iter_r;
  logic [CNT_W-1:0]  pk_r;
  logic              few_r;
  logic              ovf_r;
  logic [MEAN_W-1:0] mean_r;
  logic              out_valid_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [PCNT_W-1:0] out_pcnt_r;
  logic [FLAG_W-1:0] out_flags_r;

  logic [CNT_W-1:0]  j_cnt;
  logic [IDX_W-1:0]  j_diff;
  logic [CNT_W-1:0]  j_pk;
  logic              j_ovf;
  logic              j_few;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [CNT_W-1:0]  rem_nxt;
  logic [NUM_W-1:0]  quo_nxt;
  logic              out_free;

  assign j_cnt  = job_data[CNT_W-1:0];
  assign j_diff = job_data[CNT_W +: IDX_W];
  assign j_pk   = job_data[CNT_W+IDX_W +: CNT_W];
  assign j_ovf  = job_data[JOB_W-1];
  assign j_few  = j_pk < CNT_W'(2);

  assign job_ready = state_r == ST_IDLE;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    qbit  = trial >= {1'b0, div_r};
    if (qbit) begin
      rem_nxt = CNT_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[CNT_W-1:0];
    end
    quo_nxt = {quo_r[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            state_r <= j_few ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          if (iter_r == ITER_W'(1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && job_valid) begin
      pk_r   <= j_pk;
      few_r  <= j_few;
      ovf_r  <= j_ovf;
      quo_r  <= NUM_W'(j_diff) << FRAC_BITS;
      rem_r  <= '0;
      div_r  <= j_pk - CNT_W'(1);
      iter_r <= ITER_W'(NUM_W);
      mean_r <= sat_mean(64'(j_cnt) << FRAC_BITS);
    end else if (state_r == ST_DIV) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      iter_r <= iter_r - ITER_W'(1);
      if (iter_r == ITER_W'(1)) begin
        mean_r <= sat_mean(64'(quo_nxt));
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_mean_r  <= mean_r;
      out_pcnt_r  <= sat_pcnt(64'(pk_r));
      out_flags_r <= {ovf_r, few_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_pcnt_r, out_mean_r};
  assign out_tuser  = out_flags_r;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_r != '0))
    else $error("division by zero gap count");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_tready) |=> (state_r == ST_DONE))
    else $error("result left while output slot busy");
`endif

endmodule

`default_nettype wire

[rtl/core/peak_mean_interval.sv]
// Peak mean interval: top level joining sample front, job queue and divider back.
//
// Input stream: one amplitude sample per request on in_tdata[23:0], in_tlast
// marks the final sample of a stream. A sample is a peak when it is >= each
// existing neighbor up to two places away on either side.
// Output stream: one request per input stream, issued after its last sample.
// out_tdata holds mean peak spacing in Q16.8 (or the sample count when fewer
// than two peaks) and the saturated peak count; out_tuser holds the flags.
// Throughput: one sample per cycle. in_tready drops only while the two-entry
// job queue is full and holds back the next sample until a job leaves.
// The back takes a new stream only when idle, once the previous result has
// entered the output register. A result passes the job queue, then the
// bit-serial divider that produces one quotient bit per cycle, then the
// output register; with fewer than two peaks the divider is skipped.
// Samples beyond MAX_SAMPLES in a stream are dropped and raise the overflow flag.
// Reset clears all stream counters, the queue and the output register.
// A stalled receiver holds the result in the output register; the divider
// then waits, the queue fills, and the input stalls last.
`default_nettype none

module peak_mean_interval import pmi_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [AMP_W-1:0]      in_tdata,   // [23:0] amplitude
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [23:0] mean_interval, [40:24] peak_count
  output logic [FLAG_W-1:0]          out_tuser   // [0] few_peaks, [1] overflow
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int JOB_W = CNT_W + IDX_W + CNT_W + 1;

  logic             fq_valid;
  logic             fq_ready;
  logic [JOB_W-1:0] fq_data;
  logic             qb_valid;
  logic             qb_ready;
  logic [JOB_W-1:0] qb_data;

  pmi_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_amplitude (in_tdata),
    .in_last      (in_tlast),
    .job_valid    (fq_valid),
    .job_ready    (fq_ready),
    .job_data     (fq_data)
  );

  pmi_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QDEPTH_DEF)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  pmi_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (qb_valid),
    .job_ready  (qb_ready),
    .job_data   (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
